>>> rtl/ptp_pkg.sv
// shared constants, command/status structs and the colour distance function
// for the palette threshold packer; no dependencies
package ptp_pkg;

	localparam int MAX_SOURCE     = 4096;
	localparam int SRC_AW         = $clog2(MAX_SOURCE);
	localparam int CNT_W          = SRC_AW + 1;
	localparam int PALETTE_SIZE   = 256;
	localparam int PAL_AW         = 8;
	localparam int USED_W         = 9;
	localparam int CHANNEL_LEVELS = 64;
	localparam int CH_W           = $clog2(CHANNEL_LEVELS);
	localparam int COLOR_W        = 3 * CH_W;
	localparam int HI_SMALL       = (CHANNEL_LEVELS - 1) * (CHANNEL_LEVELS - 1);
	localparam int THR_W          = $clog2(HI_SMALL + 1);
	localparam int DIST_W         = 2 * CH_W + 2;
	localparam int FIRST_GUESS    = 50 * 8;
	localparam int BIG_CEILING    = 800;
	localparam int BIG_LIMIT      = 128;

	typedef logic [COLOR_W-1:0] color_t;

	typedef struct packed {
		logic load_out;
		logic copy_start;
		logic copy_rd;
		logic copy_wr;
		logic copy_fin;
		logic bi_init;
		logic clr_used;
		logic pass_start;
		logic halve;
		logic src_rd;
		logic cand_lat;
		logic next_k;
		logic take;
		logic skip;
		logic bi_upd;
		logic fill_init;
		logic pack_fin;
	} ptp_cmd_t;

	typedef struct packed {
		logic fits;
		logic copy_more;
		logic src_more;
		logic used_zero;
		logic reject;
		logic last_k;
		logic bi_done;
		logic fill_done;
	} ptp_status_t;

	function automatic logic [DIST_W-1:0] color_dist(input color_t a, input color_t b);
		logic [CH_W-1:0]     d;
		logic [2*CH_W-1:0]   dd;
		logic [DIST_W-1:0]   acc;
		acc = '0;
		for (int c = 0; c < 3; c++) begin
			d = (a[c*CH_W +: CH_W] > b[c*CH_W +: CH_W]) ?
				a[c*CH_W +: CH_W] - b[c*CH_W +: CH_W] :
				b[c*CH_W +: CH_W] - a[c*CH_W +: CH_W];
			// square needs the full double width
			dd = {{CH_W{1'b0}}, d};
			acc = acc + DIST_W'(dd * dd);
		end
		return acc;
	endfunction

endpackage

>>> rtl/palette_threshold_packer.sv
// channel    | dir | handshake          | content
// s_axis     | in  | s_tvalid/s_tready  | colour load or palette read request
// m_axis     | out | m_tvalid/m_tready  | palette entry with used count and overflow
// cfg        | in  | cfg_valid/cfg_ready| target_count
//
// a colour load is stored on acceptance; a read passes through the S_RDW state into the output register.
// packing after a last mark runs on the ptp_ctrl sequencer: per scan each source
// is read and compared against the kept colours, one palette compare a cycle
// through the palette ram read port; no request is taken until it finishes.
// reset clears all control state and marks every palette entry as zero.
// a stalled result holds in the output register and holds off new requests;
// target_count writes are taken only while the sequencer is idle.
// top level of the palette threshold packer; uses ptp_pkg, ptp_ctrl, ptp_dp
module palette_threshold_packer
	import ptp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // red, green, blue, index, zero pad
	input  logic        s_tlast,
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_red, out_green, out_blue, used_count, overflow, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);

	ptp_cmd_t          cmd;
	ptp_status_t       st;
	logic              idle, accept;
	color_t            out_color;
	logic [USED_W-1:0] out_used;
	logic              out_ovf;

	assign s_tready  = idle && (!m_tvalid || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = idle;

	ptp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (s_tuser),
		.last   (s_tlast),
		.st     (st),
		.cmd    (cmd),
		.idle   (idle)
	);

	// stored colour keeps red in the high bits
	ptp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.accept    (accept),
		.kind      (s_tuser),
		.in_color  ({s_tdata[5:0], s_tdata[11:6], s_tdata[17:12]}),
		.in_index  (s_tdata[25:18]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_value (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_color (out_color),
		.out_used  (out_used),
		.out_ovf   (out_ovf)
	);

	assign m_tdata = {4'b0, out_ovf, out_used, out_color[CH_W-1:0],
		out_color[2*CH_W-1:CH_W], out_color[3*CH_W-1:2*CH_W]};

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> idle)
		else $error("request taken while packing");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[26:18] <= 9'd256))
		else $error("used count beyond palette size");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser, 2))
		else $error("result without a read request");

endmodule

>>> rtl/ptp_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ptp_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/ptp_ctrl.sv
// controller state machine of the packer: sequences loads, reads, copy,
// bisection and fill scans; uses ptp_pkg
module ptp_ctrl
	import ptp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        kind,
	input  logic        last,
	input  ptp_status_t st,
	output ptp_cmd_t    cmd,
	output logic        idle
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_RDW     = 4'd1;
	localparam logic [3:0] S_CPRD    = 4'd2;
	localparam logic [3:0] S_CPWR    = 4'd3;
	localparam logic [3:0] S_SCSRC   = 4'd4;
	localparam logic [3:0] S_SCSWT   = 4'd5;
	localparam logic [3:0] S_SCPWT   = 4'd6;
	localparam logic [3:0] S_TAKE    = 4'd7;
	localparam logic [3:0] S_BIEND   = 4'd8;
	localparam logic [3:0] S_FILLINI = 4'd9;
	localparam logic [3:0] S_FILLEND = 4'd10;

	logic [3:0] state_q, state_nx;
	logic       fill_q, fill_nx;

	always_comb begin
		state_nx = state_q;
		fill_nx  = fill_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (kind) begin
						state_nx = S_RDW;
					end else if (last) begin
						if (st.fits) begin
							cmd.copy_start = 1'b1;
							state_nx       = S_CPRD;
						end else begin
							cmd.bi_init    = 1'b1;
							cmd.clr_used   = 1'b1;
							cmd.pass_start = 1'b1;
							fill_nx        = 1'b0;
							state_nx       = S_SCSRC;
						end
					end
				end
			end
			S_RDW: begin
				cmd.load_out = 1'b1;
				state_nx     = S_IDLE;
			end
			S_CPRD: begin
				if (st.copy_more) begin
					cmd.copy_rd = 1'b1;
					state_nx    = S_CPWR;
				end else begin
					cmd.copy_fin = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			S_CPWR: begin
				cmd.copy_wr = 1'b1;
				state_nx    = S_CPRD;
			end
			S_SCSRC: begin
				if (st.src_more) begin
					cmd.src_rd = 1'b1;
					state_nx   = S_SCSWT;
				end else begin
					state_nx = fill_q ? S_FILLEND : S_BIEND;
				end
			end
			S_SCSWT: begin
				cmd.cand_lat = 1'b1;
				state_nx     = st.used_zero ? S_TAKE : S_SCPWT;
			end
			S_SCPWT: begin
				if (st.reject) begin
					cmd.skip = 1'b1;
					state_nx = S_SCSRC;
				end else if (st.last_k) begin
					state_nx = S_TAKE;
				end else begin
					cmd.next_k = 1'b1;
				end
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				state_nx = S_SCSRC;
			end
			S_BIEND: begin
				cmd.bi_upd = 1'b1;
				if (st.bi_done) begin
					state_nx = S_FILLINI;
				end else begin
					cmd.clr_used   = 1'b1;
					cmd.pass_start = 1'b1;
					state_nx       = S_SCSRC;
				end
			end
			S_FILLINI: begin
				cmd.fill_init = 1'b1;
				fill_nx       = 1'b1;
				state_nx      = S_SCSRC;
			end
			S_FILLEND: begin
				if (st.fill_done) begin
					cmd.pack_fin = 1'b1;
					state_nx     = S_IDLE;
				end else begin
					cmd.halve      = 1'b1;
					cmd.pass_start = 1'b1;
					state_nx       = S_SCSRC;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			fill_q  <= fill_nx;
		end
	end

	assign idle = (state_q == S_IDLE);

endmodule

>>> rtl/ptp_dp.sv
// datapath of the packer: source and palette rams, counters, thresholds,
// distance compare and output register; uses ptp_pkg and ptp_ram
module ptp_dp
	import ptp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  ptp_cmd_t           cmd,
	output ptp_status_t        st,
	input  logic               accept,
	input  logic               kind,
	input  color_t             in_color,
	input  logic [PAL_AW-1:0]  in_index,
	input  logic               cfg_we,
	input  logic [USED_W-1:0]  cfg_value,
	output logic               out_valid,
	input  logic               out_ready,
	output color_t             out_color,
	output logic [USED_W-1:0]  out_used,
	output logic               out_ovf
);

	logic [CNT_W-1:0]  count_q, count_nx, i_q;
	logic              ovf_q;
	logic [USED_W-1:0] target_q, want, used_q, base_q;
	logic [PAL_AW-1:0] k_q, idx_q, pal_raddr, pal_waddr;
	logic [THR_W-1:0]  thr_q, hi_q, lo_q, hi_n, lo_n;
	logic [THR_W:0]    hl_sum;
	color_t            cand_q, src_rdata, pal_rdata, pal_wdata;
	logic              valid_q [PALETTE_SIZE];
	logic              load, got_ge;
	logic [DIST_W-1:0] cand_dist;

	assign load = accept && !kind;

	always_comb begin
		if (target_q == '0) begin
			want = USED_W'(1);
		end else if (target_q > USED_W'(PALETTE_SIZE)) begin
			want = USED_W'(PALETTE_SIZE);
		end else begin
			want = target_q;
		end
	end

	assign count_nx = (count_q < CNT_W'(MAX_SOURCE)) ? count_q + 1'b1 : count_q;

	// source store
	ptp_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_SOURCE)) u_src (
		.clk   (clk),
		.we    (load && (count_q < CNT_W'(MAX_SOURCE))),
		.waddr (count_q[SRC_AW-1:0]),
		.wdata (in_color),
		.raddr (i_q[SRC_AW-1:0]),
		.rdata (src_rdata)
	);

	// palette store, entries without a valid bit read as zero
	assign pal_raddr = cmd.next_k ? k_q + 1'b1 : (cmd.cand_lat ? '0 : in_index);
	assign pal_waddr = cmd.take ? used_q[PAL_AW-1:0] : i_q[PAL_AW-1:0];
	assign pal_wdata = cmd.take ? cand_q : src_rdata;

	ptp_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_SIZE)) u_pal (
		.clk   (clk),
		.we    (cmd.take || cmd.copy_wr),
		.waddr (pal_waddr),
		.wdata (pal_wdata),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	assign cand_dist = color_dist(cand_q, pal_rdata);
	assign got_ge    = used_q >= want;
	assign hi_n      = got_ge ? hi_q : thr_q;
	assign lo_n      = got_ge ? thr_q : lo_q;
	assign hl_sum    = {1'b0, hi_n} + {1'b0, lo_n};

	always_comb begin
		st.fits      = count_nx <= CNT_W'(want);
		st.copy_more = i_q < count_q;
		st.src_more  = (i_q < count_q) && (used_q < want);
		st.used_zero = used_q == '0;
		st.reject    = cand_dist <= DIST_W'(thr_q);
		st.last_k    = ({1'b0, k_q} + 1'b1) == used_q;
		st.bi_done   = {1'b0, hi_n} <= ({1'b0, lo_n} + 1'b1);
		st.fill_done = got_ge || ((used_q == base_q) && (thr_q == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			target_q  <= USED_W'(PALETTE_SIZE);
			i_q       <= '0;
			k_q       <= '0;
			used_q    <= '0;
			base_q    <= '0;
			thr_q     <= '0;
			hi_q      <= '0;
			lo_q      <= '0;
			out_valid <= 1'b0;
			for (int e = 0; e < PALETTE_SIZE; e++) begin
				valid_q[e] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				target_q <= cfg_value;
			end
			if (load) begin
				count_q <= count_nx;
				if (count_q >= CNT_W'(MAX_SOURCE)) begin
					ovf_q <= 1'b1;
				end else if (count_q == '0) begin
					ovf_q <= 1'b0;
				end
			end
			if (cmd.copy_fin) begin
				used_q  <= count_q[USED_W-1:0];
				count_q <= '0;
			end
			if (cmd.pack_fin) begin
				count_q <= '0;
			end
			if (cmd.copy_start || cmd.pass_start || cmd.fill_init) begin
				i_q <= '0;
			end else if (cmd.copy_wr || cmd.take || cmd.skip) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.cand_lat) begin
				k_q <= '0;
			end else if (cmd.next_k) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.clr_used || cmd.fill_init) begin
				used_q <= '0;
			end else if (cmd.take) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.fill_init) begin
				base_q <= '0;
			end else if (cmd.pass_start) begin
				base_q <= cmd.clr_used ? '0 : used_q;
			end
			if (cmd.bi_init) begin
				hi_q  <= (want < USED_W'(BIG_LIMIT)) ? THR_W'(HI_SMALL) : THR_W'(BIG_CEILING);
				lo_q  <= '0;
				thr_q <= THR_W'(FIRST_GUESS);
			end
			if (cmd.bi_upd) begin
				hi_q  <= hi_n;
				lo_q  <= lo_n;
				thr_q <= hl_sum[THR_W:1];
			end
			if (cmd.fill_init) begin
				thr_q <= hi_q;
				for (int e = 0; e < PALETTE_SIZE; e++) begin
					valid_q[e] <= 1'b0;
				end
			end
			if (cmd.halve) begin
				thr_q <= thr_q >> 1;
			end
			if (cmd.take) begin
				valid_q[used_q[PAL_AW-1:0]] <= 1'b1;
			end
			if (cmd.copy_wr) begin
				valid_q[i_q[PAL_AW-1:0]] <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cand_lat) begin
			cand_q <= src_rdata;
		end
		if (accept && kind) begin
			idx_q <= in_index;
		end
		if (cmd.load_out) begin
			out_color <= valid_q[idx_q] ? pal_rdata : '0;
			out_used  <= used_q;
			out_ovf   <= ovf_q;
		end
	end

endmodule
